### rtl/core/rafe_pkg.sv
// Package for the RIFF/AVI frame extractor core.
// Holds the chunk ids, parse phase codes, result beat type and FIFO sizing.
// No dependencies.
package rafe_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;

    localparam int CFG_W       = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int TALLY_W     = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_SIZE = 1'd1;

    localparam logic [CFG_W-1:0] TOTAL_LENGTH_RESET   = 24'd0;
    localparam logic [CFG_W-1:0] MAX_FRAME_SIZE_RESET = 24'd50000;
    localparam logic [CFG_W-1:0] MIN_FILE_BYTES       = 24'd12;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_LIST = 32'h5453_494C;
    localparam logic [31:0] ID_MOVI = 32'h6976_6F6D;
    localparam logic [31:0] ID_00DC = 32'h6364_3030;
    localparam logic [31:0] ID_01DC = 32'h6364_3130;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result FIFO: room for two beats is needed to take a byte.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam int TDATA_W = 40;

    typedef enum logic [7:0] {
        PH_MAGIC     = 8'b0000_0001,
        PH_HDR_ID    = 8'b0000_0010,
        PH_HDR_SIZE  = 8'b0000_0100,
        PH_LIST_TYPE = 8'b0000_1000,
        PH_SKIP      = 8'b0001_0000,
        PH_PAYLOAD   = 8'b0010_0000,
        PH_DONE      = 8'b0100_0000,
        PH_IDLE      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         payload_byte;
        logic               frame_begin;
        logic               frame_end;
        logic [1:0]         status;
        logic [TALLY_W-1:0] frames_found;
        logic               last_of_run;
    } result_t;

    // Results of one byte, in delivery order; v1 implies v0.
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } res_pair_t;

endpackage

### rtl/core/riff_avi_frame_extractor_core.sv
// Top level of the RIFF/AVI frame extractor core.
// Depends on rafe_pkg, rafe_parser and rafe_result_fifo.

// Feed a RIFF/AVI file one byte per input beat; mark byte zero with tuser to
// restart the parser (after reset the first byte counts as byte zero anyway).
// Write total_length (index 0) and max_frame_size (index 1) while idle. The
// core checks the length and the RIFF magic, walks chunk headers, enters RIFF
// and LIST movi, skips everything else, and forwards the payload of each
// accepted 00dc/01dc chunk as kind-0 beats flagged with frame begin and end.
// The byte at position total_length - 1 also yields a kind-1 summary beat with
// the status and the saturating frame count; later bytes yield nothing until
// the next restart. tlast marks the last beat caused by an input byte.
// Rate: one byte per clock while the result FIFO has room for two beats. Each
// byte is parsed in the cycle it is accepted and its beats land in a four-beat
// result FIFO; a byte is taken whenever that FIFO has room for two beats, so
// bytes yielding one beat each sustain one byte per cycle while m_tready holds
// high. The final byte of a frame-ending file yields two beats.
module riff_avi_frame_extractor_core #(
    parameter int LENGTH_BITS = rafe_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input byte stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // [0] first_byte
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] payload_byte, [8] frame_begin, [9] frame_end, [11:10] status,
    // [35:12] frames_found, [39:36] zero
    output logic [rafe_pkg::TDATA_W-1:0]     m_tdata,
    output logic                             m_tuser,   // [0] kind
    output logic                             m_tlast,   // last_of_run
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rafe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rafe_pkg::CFG_W-1:0]       cfg_data
);
    import rafe_pkg::*;

    // Keep only the bits a length counter of LENGTH_BITS can hold.
    localparam logic [CFG_W-1:0] CFG_MASK =
        (LENGTH_BITS >= CFG_W) ? '1 : CFG_W'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [CFG_W-1:0] total_length_reg;
    logic [CFG_W-1:0] max_frame_size_reg;
    logic             in_accept;
    logic             room2;
    res_pair_t        res;
    result_t          out_item;

    assign cfg_ready = 1'b1;
    assign s_tready  = room2;
    assign in_accept = s_tvalid && room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg   <= TOTAL_LENGTH_RESET;
            max_frame_size_reg <= MAX_FRAME_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOTAL_LENGTH:   total_length_reg   <= cfg_data & CFG_MASK;
                REG_MAX_FRAME_SIZE: max_frame_size_reg <= cfg_data & CFG_MASK;
                default:
                begin
                end
            endcase
        end
    end

    // Parse the accepted byte; its beats go straight into the FIFO.
    rafe_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (in_accept),
        .data_byte     (s_tdata),
        .first_byte    (s_tuser),
        .total_length  (total_length_reg),
        .max_frame_size(max_frame_size_reg),
        .res           (res)
    );

    // Drop the results of an unaccepted byte before they reach the FIFO.
    res_pair_t res_gated;

    always_comb
    begin
        res_gated    = res;
        res_gated.v0 = res.v0 && in_accept;
        res_gated.v1 = res.v1 && in_accept;
    end

    rafe_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_gated),
        .room2   (room2),
        .rd_valid(m_tvalid),
        .rd_ready(m_tready),
        .rd_item (out_item)
    );

    assign m_tdata = {4'd0, out_item.frames_found, out_item.status, out_item.frame_end,
                      out_item.frame_begin, out_item.payload_byte};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last_of_run;

endmodule

### rtl/core/rafe_parser.sv
// Chunk parser of the RIFF/AVI frame extractor: parse state and per-byte step.
// Depends on rafe_pkg.
module rafe_parser #(
    parameter int LENGTH_BITS = rafe_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [7:0]                 data_byte,
    input  logic                       first_byte,
    input  logic [rafe_pkg::CFG_W-1:0] total_length,
    input  logic [rafe_pkg::CFG_W-1:0] max_frame_size,
    output rafe_pkg::res_pair_t        res
);
    import rafe_pkg::*;

    localparam int PW = ((LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W) + 1;

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    phase_t                 phase_reg, phase_next;
    logic [1:0]             fbc_reg, fbc_next;
    logic [31:0]            word_reg, word_next;
    logic [31:0]            cid_reg, cid_next;
    logic [31:0]            clen_reg, clen_next;
    logic [31:0]            brem_reg, brem_next;
    logic [TALLY_W-1:0]     tally_reg, tally_next;
    logic [1:0]             fail_reg, fail_next;

    // Round up to even, saturating at all ones.
    function automatic logic [31:0] padded(input logic [31:0] size);
        logic [31:0] p;
        p = size + 32'd1;
        padded = (size == '1) ? '1 : {p[31:1], 1'b0};
    endfunction

    always_comb
    begin
        logic [LENGTH_BITS-1:0] pos;
        phase_t                 ph;
        logic [1:0]             fbc;
        logic [31:0]            word, cid, clen, brem, word_in, skip_n, list_pad;
        logic [TALLY_W-1:0]     tally;
        logic [1:0]             fail;
        logic                   word_done, frame_ok, pay_v, sum_v;
        result_t                pay, sum;

        if (first_byte)
        begin
            pos = '0; ph = PH_MAGIC; fbc = '0; word = '0; cid = '0;
            clen = '0; brem = '0; tally = '0; fail = STATUS_OK;
        end
        else
        begin
            pos = pos_reg; ph = phase_reg; fbc = fbc_reg; word = word_reg; cid = cid_reg;
            clen = clen_reg; brem = brem_reg; tally = tally_reg; fail = fail_reg;
        end

        pos_next = pos; phase_next = ph; fbc_next = fbc; word_next = word; cid_next = cid;
        clen_next = clen; brem_next = brem; tally_next = tally; fail_next = fail;

        word_in   = {data_byte, word[31:8]};
        word_done = (fbc == 2'd3);
        frame_ok  = (word_in != 32'd0) && (word_in <= 32'(max_frame_size)) &&
                    (34'(pos) + 34'd1 + 34'(word_in) <= 34'(total_length));
        list_pad  = padded(clen);
        skip_n    = 32'd0;
        pay_v     = 1'b0;
        sum_v     = 1'b0;

        pay = '0;
        pay.kind         = KIND_PAYLOAD;
        pay.payload_byte = data_byte;
        pay.frame_begin  = (brem == clen);
        pay.frame_end    = (brem == 32'd1);

        if (ph != PH_DONE)
        begin
            case (ph)
                PH_MAGIC:
                begin
                    if (pos == '0 && total_length < MIN_FILE_BYTES)
                    begin
                        fail_next  = STATUS_SHORT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        word_next = word_in;
                        fbc_next  = fbc + 2'd1;
                        if (word_done)
                        begin
                            cid_next = word_in;
                            if (word_in != ID_RIFF)
                            begin
                                fail_next  = STATUS_BAD_MAGIC;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_HDR_SIZE;
                            end
                        end
                    end
                end
                PH_HDR_ID:
                begin
                    word_next = word_in;
                    fbc_next  = fbc + 2'd1;
                    if (word_done)
                    begin
                        cid_next   = word_in;
                        phase_next = PH_HDR_SIZE;
                    end
                end
                PH_HDR_SIZE:
                begin
                    word_next = word_in;
                    fbc_next  = fbc + 2'd1;
                    if (word_done)
                    begin
                        clen_next = word_in;
                        if (cid == ID_RIFF)
                        begin
                            brem_next  = 32'd4;
                            phase_next = PH_SKIP;
                        end
                        else if (cid == ID_LIST)
                        begin
                            phase_next = PH_LIST_TYPE;
                        end
                        else if ((cid == ID_00DC || cid == ID_01DC) && frame_ok)
                        begin
                            brem_next  = word_in;
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            skip_n     = padded(word_in);
                            brem_next  = skip_n;
                            phase_next = (skip_n == 32'd0) ? PH_HDR_ID : PH_SKIP;
                        end
                    end
                end
                PH_LIST_TYPE:
                begin
                    word_next = word_in;
                    fbc_next  = fbc + 2'd1;
                    if (word_done)
                    begin
                        if (word_in == ID_MOVI)
                        begin
                            phase_next = PH_HDR_ID;
                        end
                        else
                        begin
                            // Clamp a LIST smaller than its type field to no skip.
                            skip_n     = (list_pad < 32'd4) ? 32'd0 : list_pad - 32'd4;
                            brem_next  = skip_n;
                            phase_next = (skip_n == 32'd0) ? PH_HDR_ID : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    brem_next = brem - 32'd1;
                    if (brem == 32'd1)
                    begin
                        phase_next = PH_HDR_ID;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_v     = 1'b1;
                    brem_next = brem - 32'd1;
                    if (brem == 32'd1)
                    begin
                        if (tally != '1)
                        begin
                            tally_next = tally + TALLY_W'(1);
                        end
                        // Skip the pad byte of an odd-sized frame.
                        skip_n     = {31'd0, clen[0] && (clen != '1)};
                        brem_next  = skip_n;
                        phase_next = (skip_n == 32'd0) ? PH_HDR_ID : PH_SKIP;
                    end
                end
                default:
                begin
                end
            endcase

            if (PW'(pos) + PW'(1) >= PW'(total_length))
            begin
                sum_v      = 1'b1;
                phase_next = PH_DONE;
            end

            if (pos != '1)
            begin
                pos_next = pos + LENGTH_BITS'(1);
            end
        end

        sum = '0;
        sum.kind         = KIND_SUMMARY;
        sum.status       = fail_next;
        sum.frames_found = tally_next;
        sum.last_of_run  = 1'b1;
        pay.last_of_run  = !sum_v;

        res.v0 = pay_v || sum_v;
        res.r0 = pay_v ? pay : sum;
        res.v1 = pay_v && sum_v;
        res.r1 = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_MAGIC;
            fbc_reg   <= '0;
            word_reg  <= '0;
            cid_reg   <= '0;
            clen_reg  <= '0;
            brem_reg  <= '0;
            tally_reg <= '0;
            fail_reg  <= STATUS_OK;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            word_reg  <= word_next;
            cid_reg   <= cid_next;
            clen_reg  <= clen_next;
            brem_reg  <= brem_next;
            tally_reg <= tally_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

### rtl/core/rafe_result_fifo.sv
// Result FIFO of the RIFF/AVI frame extractor: takes up to two beats per cycle,
// delivers one. Depends on rafe_pkg.
module rafe_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  rafe_pkg::res_pair_t wr,
    output logic                room2,
    output logic                rd_valid,
    input  logic                rd_ready,
    output rafe_pkg::result_t   rd_item
);
    import rafe_pkg::*;

    result_t                entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = entry_reg[rp_reg];
    assign room2    = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = wp_reg + RES_PTR_W'(wr.v0) + RES_PTR_W'(wr.v1);
        rp_next  = rp_reg + RES_PTR_W'(pop);
        cnt_next = cnt_reg + RES_CNT_W'(wr.v0) + RES_CNT_W'(wr.v1) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.v0)
        begin
            entry_reg[wp_reg] <= wr.r0;
        end
        if (wr.v1)
        begin
            entry_reg[wp_reg + RES_PTR_W'(1)] <= wr.r1;
        end
    end

endmodule

### test/tb_riff_avi_frame_extractor_core.sv
`timescale 1ns / 100ps
// Testbench for riff_avi_frame_extractor_core: streams directed and random RIFF/AVI
// images through the core and checks every result beat against a scoreboard.
// Depends on rafe_pkg and riff_avi_frame_extractor_core.
module tb_riff_avi_frame_extractor_core;
    import rafe_pkg::*;

    // Tracks the parse of the byte stream and holds the beats the core owes us.
    class frame_scoreboard;
        bit [CFG_W-1:0]   file_len;
        bit [CFG_W-1:0]   frame_limit;
        bit [CFG_W-1:0]   at_byte;
        phase_t           phase;
        bit [1:0]         word_fill;
        bit [31:0]        word;
        bit [31:0]        chunk_id;
        bit [31:0]        chunk_len;
        bit [31:0]        remain;
        bit [TALLY_W-1:0] tally;
        bit [1:0]         fail;
        result_t          owed[$];
        int               errors;
        int               parsed;

        function new();
            file_len    = TOTAL_LENGTH_RESET;
            frame_limit = MAX_FRAME_SIZE_RESET;
            errors      = 0;
            parsed      = 0;
            restart();
        endfunction

        function void restart();
            at_byte   = '0;
            phase     = PH_MAGIC;
            word_fill = '0;
            word      = '0;
            chunk_id  = '0;
            chunk_len = '0;
            remain    = '0;
            tally     = '0;
            fail      = STATUS_OK;
        endfunction

        // Round up to even, saturating at 32 bits.
        function bit [31:0] padded(bit [31:0] size);
            bit [32:0] p;
            p = ({1'b0, size} + 33'd1) & ~33'd1;
            return p[32] ? 32'hFFFF_FFFF : p[31:0];
        endfunction

        function void skip_for(bit [31:0] n);
            remain = n;
            phase  = (n == 0) ? PH_HDR_ID : PH_SKIP;
        endfunction

        // Shift in one little-endian byte; true once a full word is in.
        function bit shift_in(bit [7:0] b);
            word      = {b, word[31:8]};
            word_fill = word_fill + 2'd1;
            return word_fill == 2'd0;
        endfunction

        function void write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_W-1:0] value);
            if (idx == REG_TOTAL_LENGTH)
                file_len = value;
            else if (idx == REG_MAX_FRAME_SIZE)
                frame_limit = value;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Advance the parse by one accepted byte and queue the beats it causes.
        function void note_byte(bit [7:0] b, bit first);
            result_t   r [2];
            int        n;
            bit [23:0] pos;
            bit [31:0] p;
            r[0] = '0;
            r[1] = '0;
            n    = 0;
            if (first)
                restart();
            if (phase == PH_DONE)
                return;
            parsed++;
            pos = at_byte;
            case (phase)
                PH_MAGIC:
                begin
                    if (pos == 0 && file_len < MIN_FILE_BYTES)
                    begin
                        fail  = STATUS_SHORT;
                        phase = PH_IDLE;
                    end
                    else if (shift_in(b))
                    begin
                        chunk_id = word;
                        if (chunk_id != ID_RIFF)
                        begin
                            fail  = STATUS_BAD_MAGIC;
                            phase = PH_IDLE;
                        end
                        else
                            phase = PH_HDR_SIZE;
                    end
                end
                PH_HDR_ID:
                begin
                    if (shift_in(b))
                    begin
                        chunk_id = word;
                        phase    = PH_HDR_SIZE;
                    end
                end
                PH_HDR_SIZE:
                begin
                    if (shift_in(b))
                    begin
                        chunk_len = word;
                        if (chunk_id == ID_RIFF)
                            skip_for(32'd4);
                        else if (chunk_id == ID_LIST)
                            phase = PH_LIST_TYPE;
                        else if ((chunk_id == ID_00DC || chunk_id == ID_01DC) && word != 0
                                 && word <= {8'b0, frame_limit}
                                 && {40'b0, pos} + 64'd1 + {32'b0, word} <= {40'b0, file_len})
                        begin
                            remain = word;
                            phase  = PH_PAYLOAD;
                        end
                        else
                            skip_for(padded(word));
                    end
                end
                PH_LIST_TYPE:
                begin
                    if (shift_in(b))
                    begin
                        if (word == ID_MOVI)
                            phase = PH_HDR_ID;
                        else
                        begin
                            // a LIST too short to cover its own type skips nothing
                            p = padded(chunk_len);
                            skip_for(p < 32'd4 ? 32'd0 : p - 32'd4);
                        end
                    end
                end
                PH_SKIP:
                begin
                    remain = remain - 32'd1;
                    if (remain == 0)
                        phase = PH_HDR_ID;
                end
                PH_PAYLOAD:
                begin
                    r[0].kind         = KIND_PAYLOAD;
                    r[0].payload_byte = b;
                    r[0].frame_begin  = (remain == chunk_len);
                    r[0].frame_end    = (remain == 32'd1);
                    n = 1;
                    remain = remain - 32'd1;
                    if (remain == 0)
                    begin
                        if (tally != {TALLY_W{1'b1}})
                            tally = tally + TALLY_W'(1);
                        skip_for(padded(chunk_len) - chunk_len);
                    end
                end
                default:
                begin
                end
            endcase
            // summary on the last byte of the file
            if ({1'b0, pos} + 25'd1 >= {1'b0, file_len})
            begin
                r[n].kind         = KIND_SUMMARY;
                r[n].status       = fail;
                r[n].frames_found = tally;
                n++;
                phase = PH_DONE;
            end
            if (at_byte != 24'hFF_FFFF)
                at_byte = at_byte + 24'd1;
            if (n > 0)
                r[n-1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++)
                owed.push_back(r[i]);
        endfunction

        function void match(string what, bit [31:0] want, bit [31:0] got);
            if (want != got)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got 0x%0h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            match("kind", 32'(want.kind), 32'(got.kind));
            match("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            match("frame_begin", 32'(want.frame_begin), 32'(got.frame_begin));
            match("frame_end", 32'(want.frame_end), 32'(got.frame_end));
            match("status", 32'(want.status), 32'(got.status));
            match("frames_found", 32'(want.frames_found), 32'(got.frames_found));
            match("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    frame_scoreboard sb;
    result_t         seen;
    bit [7:0]        image[$];
    int              burst_left = 0;
    int              ready_tick = 0;
    int              ready_mode = 0;
    bit [7:0]        ready_pattern = 8'hFF;

    riff_avi_frame_extractor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Sample all three channels at the rising edge. Register writes and
    // input beats never share a cycle, and a result beat always trails the
    // byte that caused it, so the order below is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                seen.kind         = m_tuser;
                seen.payload_byte = m_tdata[7:0];
                seen.frame_begin  = m_tdata[8];
                seen.frame_end    = m_tdata[9];
                seen.status       = m_tdata[11:10];
                seen.frames_found = m_tdata[35:12];
                seen.last_of_run  = m_tlast;
                sb.check_beat(seen);
            end
        end
    end

    // Result-side back-pressure: periodically pick a new random stall style.
    // Mode 0 gives long stretches with no stall at all.
    always @(negedge clk)
    begin
        ready_tick++;
        if (ready_tick % 128 == 0)
        begin
            ready_mode    = $urandom_range(0, 3);
            ready_pattern = 8'($urandom_range(1, 255));
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ready_pattern[0];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
    end

    // Send one byte; open a gap whenever the current burst runs out.
    // Called and returns at a falling edge.
    task automatic send_byte(input bit [7:0] b, input bit first);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Hold the sender until every owed beat is out, then let the core settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stream the image; byte zero carries the restart mark when asked, and a
    // rare stray mark restarts the parser mid-file.
    task automatic send_image(input bit mark_start);
        for (int i = 0; i < image.size(); i++)
            send_byte(image[i], (i == 0) ? mark_start : ($urandom_range(0, 199) == 0));
    endtask

    function automatic void put_word(bit [31:0] w);
        for (int i = 0; i < 4; i++)
            image.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_noise(int count);
        for (int i = 0; i < count; i++)
            image.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Build one file image: mostly well-formed chunk sequences with random
    // content, with junk, broken headers and oversized chunks mixed in.
    function automatic void build_image();
        int        chunks;
        int        pick;
        bit [31:0] size;
        bit [31:0] span;
        image.delete();
        if ($urandom_range(0, 11) == 0)
        begin
            put_noise($urandom_range(1, 30));
            return;
        end
        put_word(ID_RIFF);
        put_word($urandom());
        put_word(($urandom_range(0, 3) == 0) ? $urandom() : 32'h2049_5641);
        chunks = $urandom_range(1, 6);
        for (int c = 0; c < chunks; c++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // frame chunk, odd sizes get a pad byte
                put_word($urandom_range(0, 1) ? ID_01DC : ID_00DC);
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                put_word(size);
                put_noise(size + size[0]);
            end
            else if (pick < 50)
            begin
                put_word(ID_LIST);
                put_word($urandom());
                put_word(ID_MOVI);
            end
            else if (pick < 63)
            begin
                // other LIST, sizes below 4 included
                size = $urandom_range(0, 10);
                put_word(ID_LIST);
                put_word(size);
                put_word($urandom());
                span = sb.padded(size);
                put_noise(span < 4 ? 0 : span - 4);
            end
            else if (pick < 76)
            begin
                size = $urandom_range(0, 9);
                put_word($urandom());
                put_word(size);
                put_noise(sb.padded(size));
            end
            else if (pick < 81)
            begin
                put_word(ID_RIFF);
                put_word($urandom());
                put_word($urandom());
            end
            else if (pick < 87)
                put_noise($urandom_range(1, 6));
            else if (pick < 94)
            begin
                // huge size: nothing after it is parsed
                put_word(pick[0] ? ID_00DC : $urandom());
                case ($urandom_range(0, 2))
                    0: put_word(32'hFFFF_FFFF);
                    1: put_word(32'hFFFF_FFFE);
                    default: put_word($urandom());
                endcase
                put_noise($urandom_range(0, 8));
                break;
            end
            else
            begin
                // trailing partial header
                put_noise($urandom_range(1, 7));
                break;
            end
        end
    endfunction

    initial
    begin
        int        pick;
        int        len;
        bit [23:0] length_reg;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // No restart mark after reset: byte zero with total_length still at
        // zero gives a short-file summary; the next byte is ignored, and a
        // marked byte restarts and reports again.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Short file: three bytes, summary on the last one.
        wait_idle();
        write_reg(REG_TOTAL_LENGTH, 24'd3);
        write_reg(REG_MAX_FRAME_SIZE, 24'hFF_FFFF);
        send_byte(8'h52, 1'b1);
        send_byte(8'h49, 1'b0);
        send_byte(8'h46, 1'b0);

        // Bad magic decided on byte three, summary on byte eleven.
        wait_idle();
        write_reg(REG_TOTAL_LENGTH, 24'd12);
        image.delete();
        put_word(32'h5846_4952);
        put_word(32'hFFFF_FFFF);
        put_word(32'h0000_0000);
        send_image(1'b1);

        // Random files, each with its own register setting most of the time.
        // Waiting for idle before each write also pauses the sender until
        // every owed beat has come back.
        while (sb.parsed < 1250)
        begin
            build_image();
            len = image.size();
            if ($urandom_range(0, 4) != 0)
            begin
                wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    length_reg = 24'(len);
                else if (pick < 78)
                    length_reg = 24'($urandom_range(0, len - 1));
                else if (pick < 88)
                    length_reg = 24'(len + $urandom_range(1, 8));
                else if (pick < 92)
                    length_reg = 24'hFF_FFFF;
                else if (pick < 95)
                    length_reg = 24'd0;
                else
                    length_reg = 24'($urandom_range(1, 11));
                write_reg(REG_TOTAL_LENGTH, length_reg);
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 4))
                        0: write_reg(REG_MAX_FRAME_SIZE, 24'd0);
                        1: write_reg(REG_MAX_FRAME_SIZE, 24'hFF_FFFF);
                        2: write_reg(REG_MAX_FRAME_SIZE, MAX_FRAME_SIZE_RESET);
                        3: write_reg(REG_MAX_FRAME_SIZE, 24'($urandom_range(1, 12)));
                        default: write_reg(REG_MAX_FRAME_SIZE, 24'($urandom()));
                    endcase
                end
            end
            send_image($urandom_range(0, 15) != 0);
            // bytes past the end of the file
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end

        // Drain, then give the core time to show any stray beat.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
